### hw/rtl/cbb_pkg.sv
// Shared types and widths for the clipped box blur.
package cbb_pkg;

    localparam int W_W    = 13;  // frame width, up to 4096
    localparam int H_W    = 14;  // frame height / input row, up to 8192
    localparam int ROW_W  = 13;  // row index
    localparam int COL_W  = 12;  // column index
    localparam int R_W    = 4;   // radius, up to 15
    localparam int RING_W = 6;   // ring row index, up to 47 rows
    localparam int CNT_W  = 10;  // pixels in a window, up to 31*31
    localparam int SUM_W  = 34;  // 24-bit value summed over a full window
    localparam int STEP_W = 6;   // divider step counter
    localparam int CFG_DW = 13;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_COLOR  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_FLUSH,
        ST_DIV,
        ST_HOLD
    } back_state_t;

    // effective frame settings
    typedef struct packed {
        logic [W_W-1:0] w;
        logic [H_W-1:0] h;
        logic [R_W-1:0] r;
        logic           color;
    } cfg_t;

    // one output to compute
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [RING_W-1:0] ring;
        logic              last;
    } job_t;

    // line store write from the front
    typedef struct packed {
        logic              en;
        logic [RING_W-1:0] ring;
        logic [COL_W-1:0]  col;
        logic [23:0]       data;
    } wr_t;

endpackage

### hw/rtl/cbb_front.sv
// Front end: config registers, input/output position tracking, job issue.
module cbb_front #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int RING_ROWS  = 23
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [1:0]           cfg_index,
    input  logic [12:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [23:0]          pixel_in,
    input  logic                 q_full,
    output logic                 push,
    output cbb_pkg::job_t        job,
    output cbb_pkg::wr_t         wr,
    output cbb_pkg::cfg_t        cfg
);
    import cbb_pkg::*;

    logic [2:0]  radius_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        color_reg;

    logic [H_W-1:0]    in_row_reg, in_row_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [RING_W-1:0] in_ring_reg, in_ring_next;
    logic [ROW_W-1:0]  emit_row_reg, emit_row_next;
    logic [COL_W-1:0]  emit_col_reg, emit_col_next;
    logic [RING_W-1:0] emit_ring_reg, emit_ring_next;

    logic [W_W-1:0] w;
    logic [H_W-1:0] h;
    logic [R_W-1:0] r;
    logic           fire, wr_en, emit, last, ready_win;
    logic [H_W:0]   need_row;
    logic [W_W:0]   need_col;

    always_comb
    begin
        r = (32'(radius_reg) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_reg);
        if (width_reg == '0)
            w = W_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w = W_W'(MAX_WIDTH);
        else
            w = W_W'(width_reg);
        if (height_reg == '0)
            h = H_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h = H_W'(MAX_HEIGHT);
        else
            h = H_W'(height_reg);
    end

    assign cfg = '{w: w, h: h, r: r, color: color_reg};

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign wr_en    = fire && (op == OP_PIXEL) && (in_row_reg < h);

    // input position after this item's pixel is stored
    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        in_ring_next = in_ring_reg;
        if (wr_en)
        begin
            if (W_W'(in_col_reg) + W_W'(1) >= w)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + H_W'(1);
                in_ring_next = (32'(in_ring_reg) == RING_ROWS - 1) ? '0
                             : in_ring_reg + RING_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        need_row = (H_W+1)'(emit_row_reg) + (H_W+1)'(r);
        if (need_row > (H_W+1)'(h) - (H_W+1)'(1))
            need_row = (H_W+1)'(h) - (H_W+1)'(1);
        need_col = (W_W+1)'(emit_col_reg) + (W_W+1)'(r);
        if (need_col > (W_W+1)'(w) - (W_W+1)'(1))
            need_col = (W_W+1)'(w) - (W_W+1)'(1);
        ready_win = (in_row_next >= h)
                 || ((H_W+1)'(in_row_next) > need_row)
                 || (((H_W+1)'(in_row_next) == need_row)
                     && ((W_W+1)'(in_col_next) > need_col));
    end

    assign emit = fire && (H_W'(emit_row_reg) < h) && ready_win;
    assign last = (H_W'(emit_row_reg) == h - H_W'(1))
               && (W_W'(emit_col_reg) == w - W_W'(1));
    assign push = emit;
    assign job  = '{row: emit_row_reg, col: emit_col_reg, ring: emit_ring_reg, last: last};
    assign wr   = '{en: wr_en, ring: in_ring_reg, col: in_col_reg, data: pixel_in};

    always_comb
    begin
        emit_row_next  = emit_row_reg;
        emit_col_next  = emit_col_reg;
        emit_ring_next = emit_ring_reg;
        if (emit)
        begin
            if (W_W'(emit_col_reg) + W_W'(1) >= w)
            begin
                emit_col_next  = '0;
                emit_row_next  = emit_row_reg + ROW_W'(1);
                emit_ring_next = (32'(emit_ring_reg) == RING_ROWS - 1) ? '0
                               : emit_ring_reg + RING_W'(1);
            end
            else
            begin
                emit_col_next = emit_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= 3'd1;
            width_reg     <= 11'd640;
            height_reg    <= 13'd480;
            color_reg     <= 1'b1;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_ring_reg   <= '0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_ring_reg <= '0;
        end
        else if (cfg_write_en || (emit && last))
        begin
            // any write, or the last output, starts a new frame
            if (cfg_write_en)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_RADIUS: radius_reg <= cfg_data[2:0];
                    REG_WIDTH:  width_reg  <= cfg_data[10:0];
                    REG_HEIGHT: height_reg <= cfg_data[12:0];
                    REG_COLOR:  color_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            // after a frame end the ring carries on, so rows that queued
            // jobs of the old frame still read are not overwritten
            in_ring_reg   <= cfg_write_en ? '0 : in_ring_next;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_ring_reg <= cfg_write_en ? '0 : in_ring_next;
        end
        else
        begin
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            in_ring_reg   <= in_ring_next;
            emit_row_reg  <= emit_row_next;
            emit_col_reg  <= emit_col_next;
            emit_ring_reg <= emit_ring_next;
        end
    end

endmodule

### hw/rtl/cbb_queue.sv
// Two-entry job queue between front and back.
module cbb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cbb_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output cbb_pkg::job_t head
);
    import cbb_pkg::*;

    job_t       slot_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

### hw/rtl/cbb_back.sv
// Back end: line store, window accumulation and iterative division.
module cbb_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int RING_ROWS = 23
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cbb_pkg::cfg_t cfg,
    input  cbb_pkg::wr_t  wr,
    input  logic          q_empty,
    input  cbb_pkg::job_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [23:0]   pixel_out,
    output logic [11:0]   out_row,
    output logic [9:0]    out_column,
    output logic          frame_end
);
    import cbb_pkg::*;

    localparam int DEPTH  = RING_ROWS * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;
    logic [ADDR_W-1:0] waddr, raddr;

    back_state_t state_reg, state_next;
    logic issue, div_step, start;

    logic [RING_W-1:0] ring_reg;
    logic [COL_W-1:0]  x_reg, c0_reg, c1_reg;
    logic [4:0]        rows_left_reg;
    logic              rd_pend_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic              last_reg;
    logic [STEP_W-1:0] step_reg;

    logic [SUM_W-1:0]  whole_reg, whole_add;
    logic [CNT_W+7:0]  hi_reg, mid_reg, lo_reg, hi_add, mid_add, lo_add;
    logic [CNT_W-1:0]  cnt_reg, cnt_add, div_reg;
    logic [SUM_W-1:0]  quo_reg [4];
    logic [CNT_W:0]    rem_reg [4];

    // window bounds for the job at the head of the queue
    logic [R_W-1:0]    d, r1off;
    logic [H_W-1:0]    rows_below;
    logic [RING_W-1:0] ring0;
    logic [COL_W-1:0]  c0, c1;
    logic [W_W:0]      col_hi;
    logic              last_issue;

    assign waddr = ADDR_W'(32'(wr.ring) * MAX_WIDTH + 32'(wr.col));
    assign raddr = ADDR_W'(32'(ring_reg) * MAX_WIDTH + 32'(x_reg));

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[waddr] <= wr.data;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            rd_data_reg <= mem[raddr];
    end

    always_comb
    begin
        d = (ROW_W'(cfg.r) > head.row) ? R_W'(head.row) : cfg.r;
        rows_below = cfg.h - H_W'(1) - H_W'(head.row);
        r1off = (rows_below < H_W'(cfg.r)) ? R_W'(rows_below) : cfg.r;
        ring0 = (head.ring >= RING_W'(d)) ? head.ring - RING_W'(d)
              : RING_W'(32'(head.ring) + RING_ROWS - 32'(d));
        c0 = (head.col >= COL_W'(cfg.r)) ? head.col - COL_W'(cfg.r) : '0;
        col_hi = (W_W+1)'(head.col) + (W_W+1)'(cfg.r);
        c1 = (col_hi > (W_W+1)'(cfg.w) - (W_W+1)'(1)) ? COL_W'(cfg.w - W_W'(1))
           : COL_W'(col_hi);
    end

    assign last_issue = (x_reg == c1_reg) && (rows_left_reg == '0);

    always_comb
    begin
        whole_add = whole_reg + SUM_W'(rd_data_reg);
        hi_add    = hi_reg  + (CNT_W+8)'(rd_data_reg[23:16]);
        mid_add   = mid_reg + (CNT_W+8)'(rd_data_reg[15:8]);
        lo_add    = lo_reg  + (CNT_W+8)'(rd_data_reg[7:0]);
        cnt_add   = cnt_reg + CNT_W'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (!q_empty) state_next = ST_SUM;
            ST_SUM:   if (last_issue) state_next = ST_FLUSH;
            ST_FLUSH: state_next = ST_DIV;
            ST_DIV:   if (step_reg == STEP_W'(SUM_W - 1)) state_next = ST_HOLD;
            ST_HOLD:  if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        start     = 1'b0;
        issue     = 1'b0;
        div_step  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:  start     = !q_empty;
            ST_SUM:   issue     = 1'b1;
            ST_FLUSH: ;
            ST_DIV:   div_step  = 1'b1;
            ST_HOLD:  out_valid = 1'b1;
            default:  ;
        endcase
    end

    assign pop = start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ring_reg      <= ring0;
            x_reg         <= c0;
            c0_reg        <= c0;
            c1_reg        <= c1;
            rows_left_reg <= 5'(d) + 5'(r1off);
            row_reg       <= head.row;
            col_reg       <= head.col;
            last_reg      <= head.last;
            whole_reg     <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            lo_reg        <= '0;
            cnt_reg       <= '0;
        end
        if (issue)
        begin
            if (x_reg == c1_reg)
            begin
                x_reg         <= c0_reg;
                rows_left_reg <= rows_left_reg - 5'd1;
                ring_reg      <= (32'(ring_reg) == RING_ROWS - 1) ? '0
                               : ring_reg + RING_W'(1);
            end
            else
            begin
                x_reg <= x_reg + COL_W'(1);
            end
        end
        if (issue && rd_pend_reg)
        begin
            whole_reg <= whole_add;
            hi_reg    <= hi_add;
            mid_reg   <= mid_add;
            lo_reg    <= lo_add;
            cnt_reg   <= cnt_add;
        end
        if (state_reg == ST_FLUSH)
        begin
            // final pixel goes straight into the dividers
            quo_reg[0] <= whole_add;
            quo_reg[1] <= SUM_W'(hi_add);
            quo_reg[2] <= SUM_W'(mid_add);
            quo_reg[3] <= SUM_W'(lo_add);
            for (int i = 0; i < 4; i++)
                rem_reg[i] <= '0;
            div_reg  <= cnt_add;
            step_reg <= '0;
        end
        if (div_step)
        begin
            // one restoring step on each of the four dividers
            for (int i = 0; i < 4; i++)
            begin
                logic [CNT_W:0] t;
                logic           ge;
                t  = {rem_reg[i][CNT_W-1:0], quo_reg[i][SUM_W-1]};
                ge = (t >= {1'b0, div_reg});
                rem_reg[i] <= ge ? t - {1'b0, div_reg} : t;
                quo_reg[i] <= {quo_reg[i][SUM_W-2:0], ge};
            end
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign pixel_out  = cfg.color ? {quo_reg[1][7:0], quo_reg[2][7:0], quo_reg[3][7:0]}
                                  : quo_reg[0][23:0];
    assign out_row    = row_reg[11:0];
    assign out_column = col_reg[9:0];
    assign frame_end  = last_reg;

    a_hold_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && !out_ready) |=> (state_reg == ST_HOLD))
        else $error("result dropped before it was taken");

    a_pend_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == ST_SUM || state_reg == ST_FLUSH))
        else $error("line store read outside accumulation");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_reg != '0))
        else $error("window count is zero");

endmodule

### hw/rtl/clipped_box_blur.sv
// Top level of the clipped box blur filter.
// Streaming box blur over a raster-order frame: each output is the truncated mean of the
// square window of the configured radius, clipped at the frame borders. Each output pixel
// takes a job pickup, then W window reads from the line store, one per clock, with W the
// number of window pixels inside the frame (up to 225 at radius 7), then a flush, a 34-step
// restoring divide and the result handoff, which waits while out_ready is low. Input items
// pass through a two-entry job queue and are taken one per clock while it has room.
// Outputs lag input by about radius rows; drain items (op = 1) flush the rest of a frame.
// Any register write restarts the frame.
module clipped_box_blur #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [23:0] pixel_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] pixel_out,
    output logic [11:0] out_row,
    output logic [9:0]  out_column,
    output logic        frame_end
);
    import cbb_pkg::*;

    localparam int RING_ROWS = 3 * MAX_RADIUS + 2;

    logic q_full, q_empty, push, pop;
    job_t job, head;
    wr_t  wr;
    cfg_t cfg;

    cbb_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RING_ROWS  (RING_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .pixel_in     (pixel_in),
        .q_full       (q_full),
        .push         (push),
        .job          (job),
        .wr           (wr),
        .cfg          (cfg)
    );

    cbb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    cbb_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .RING_ROWS (RING_ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .wr         (wr),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_column (out_column),
        .frame_end  (frame_end)
    );

endmodule
